// ----- src/sfbeq_pkg.sv -----
// ----------------------------------------------------------------------------
// sfbeq_pkg
// shared types and constants of the stereo five-band biquad equaliser
// ----------------------------------------------------------------------------
package sfbeq_pkg;

    localparam int BANDS_DEF      = 5;
    localparam int COEF_FRAC_DEF  = 28;
    localparam int STATE_FRAC_DEF = 8;
    localparam int NUM_SLOTS      = 5;
    localparam int ACC_W          = 67;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [2:0]         band_sel;
        logic [2:0]         coef_sel;
        logic signed [31:0] coef_value;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } out_word_t;

    // sample pair moving along the chain of sections
    typedef struct packed {
        logic               valid;
        logic signed [31:0] left;
        logic signed [31:0] right;
    } tok_t;

    typedef struct packed {
        logic               en;
        logic [2:0]         band;
        logic [2:0]         slot;
        logic signed [31:0] value;
    } coef_wr_t;

endpackage

// ----- src/sfbeq_cell.sv -----
// ----------------------------------------------------------------------------
// sfbeq_cell
// one biquad section: own coefficients, left and right history, shared mac
// ----------------------------------------------------------------------------
module sfbeq_cell #(
    parameter int IDX       = 0,
    parameter int COEF_FRAC = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sfbeq_pkg::tok_t   tok_in,
    input  sfbeq_pkg::coef_wr_t coef_wr,
    input  logic              clear,
    output sfbeq_pkg::tok_t   tok_out
);
    import sfbeq_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< COEF_FRAC;
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W)'(64'sh7fff_ffff);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W)'(64'sh8000_0000);
    localparam logic [3:0] LAST_ISSUE = 4'd9;
    localparam logic [3:0] FIN       = 4'd11;

    logic signed [31:0] coef_reg [NUM_SLOTS];
    logic signed [31:0] hist_reg [2][4];   // x1 x2 y1 y2 per channel
    logic signed [31:0] x_reg [2];
    logic               run_reg;
    logic [3:0]         cnt_reg;
    logic signed [63:0] prod_reg;
    logic               pv_reg, pch_reg, pneg_reg;
    logic signed [ACC_W-1:0] acc_reg [2];
    tok_t               out_reg;

    logic               ch;
    logic [2:0]         slot;
    logic signed [31:0] opa, opb;
    logic signed [63:0] prod_next;
    logic signed [ACC_W-1:0] pext, add_val;
    logic signed [ACC_W-1:0] shl, shr;
    logic signed [31:0] y_l, y_r;

    always_comb
    begin
        ch   = (cnt_reg >= 4'd5);
        slot = ch ? 3'(cnt_reg - 4'd5) : cnt_reg[2:0];
        opa  = 32'sd0;
        opb  = 32'sd0;
        case (slot)
            SLOT_B0: begin opa = coef_reg[0]; opb = x_reg[ch];       end
            SLOT_B1: begin opa = coef_reg[1]; opb = hist_reg[ch][0]; end
            SLOT_B2: begin opa = coef_reg[2]; opb = hist_reg[ch][1]; end
            SLOT_A1: begin opa = coef_reg[3]; opb = hist_reg[ch][2]; end
            SLOT_A2: begin opa = coef_reg[4]; opb = hist_reg[ch][3]; end
            default: begin opa = 32'sd0;      opb = 32'sd0;          end
        endcase
        prod_next = opa * opb;
        pext      = {{(ACC_W-64){prod_reg[63]}}, prod_reg};
        add_val   = pneg_reg ? -pext : pext;
        // floor shift, then clamp to 32 bits
        shl = acc_reg[0] >>> COEF_FRAC;
        shr = acc_reg[1] >>> COEF_FRAC;
        y_l = (shl > SAT_HI) ? 32'sh7fff_ffff : (shl < SAT_LO) ? -32'sh8000_0000 : shl[31:0];
        y_r = (shr > SAT_HI) ? 32'sh7fff_ffff : (shr < SAT_LO) ? -32'sh8000_0000 : shr[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            cnt_reg       <= 4'd0;
            pv_reg        <= 1'b0;
            out_reg.valid <= 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++)
                coef_reg[s] <= (s == 0) ? ONE : 32'sd0;
            for (int c = 0; c < 2; c++)
                for (int k = 0; k < 4; k++)
                    hist_reg[c][k] <= 32'sd0;
        end
        else
        begin
            out_reg.valid <= 1'b0;
            pv_reg        <= run_reg && (cnt_reg <= LAST_ISSUE);
            if (coef_wr.en && (5'(coef_wr.band) == 5'(IDX)) && (coef_wr.slot < 3'(NUM_SLOTS)))
                coef_reg[coef_wr.slot] <= coef_wr.value;
            if (clear)
            begin
                for (int c = 0; c < 2; c++)
                    for (int k = 0; k < 4; k++)
                        hist_reg[c][k] <= 32'sd0;
            end
            if (tok_in.valid)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == FIN)
                begin
                    run_reg       <= 1'b0;
                    out_reg.valid <= 1'b1;
                    out_reg.left  <= y_l;
                    out_reg.right <= y_r;
                    for (int c = 0; c < 2; c++)
                    begin
                        hist_reg[c][1] <= hist_reg[c][0];
                        hist_reg[c][0] <= x_reg[c];
                        hist_reg[c][3] <= hist_reg[c][2];
                    end
                    hist_reg[0][2] <= y_l;
                    hist_reg[1][2] <= y_r;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pch_reg  <= ch;
        pneg_reg <= (slot >= SLOT_A1);
        if (tok_in.valid)
        begin
            x_reg[0]   <= tok_in.left;
            x_reg[1]   <= tok_in.right;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
        end
        else if (pv_reg)
            acc_reg[pch_reg] <= acc_reg[pch_reg] + add_val;
    end

    assign tok_out = out_reg;

endmodule

// ----- src/stereo_five_band_biquad_eq_core.sv -----
// ----------------------------------------------------------------------------
// stereo_five_band_biquad_eq_core
// stereo equaliser: a chain of biquad section cells, one per band
// ----------------------------------------------------------------------------
//  channel | signals                       | word
//  in      | in_valid in_ready in_data     | in_word_t (frame, load, clear)
//  out     | out_valid out_ready out_data  | out_word_t (one per frame)
//  cfg     | cfg_valid cfg_ready cfg_data  | eq_enable
//
//  a filtered frame passes through each band cell in turn (ten mac steps on
//  one 32x32 multiplier, one drain, one finish, one hand-off), then through
//  the hold and output stages; a new word is taken only while no frame is in
//  flight and the hold stage is empty.
//  loads and clears act when taken; a bypassed frame skips the band cells.
//  one frame is in flight at a time; a finished word moves from the hold
//  stage into a free output stage, so a new word can be taken while out_valid stalls.
//  reset restores pass-through coefficients, zero history and eq enabled.
module stereo_five_band_biquad_eq_core #(
    parameter int BANDS      = sfbeq_pkg::BANDS_DEF,
    parameter int COEF_FRAC  = sfbeq_pkg::COEF_FRAC_DEF,
    parameter int STATE_FRAC = sfbeq_pkg::STATE_FRAC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sfbeq_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sfbeq_pkg::out_word_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    import sfbeq_pkg::*;

    localparam logic [31:0] FRAC_MASK = 32'((64'd1 << STATE_FRAC) - 64'd1);

    logic      enable_reg;
    logic      busy_reg;
    logic      hold_valid_reg;
    out_word_t hold_reg;
    logic      out_valid_reg;
    out_word_t out_reg;

    logic      acc_in;
    tok_t      start_tok;
    tok_t      chain [BANDS+1];
    coef_wr_t  coef_wr;
    logic      clear;
    logic      done;
    logic      hold_move;
    logic signed [15:0] res_l, res_r;

    function automatic logic signed [15:0] to_sample(input logic signed [31:0] v);
        logic signed [31:0] q;
        q = v >>> STATE_FRAC;
        // truncate toward zero
        if (v[31] && ((v & FRAC_MASK) != 32'd0))
            q = q + 32'sd1;
        if (q > 32'sd32767)
            return 16'sh7fff;
        else if (q < -32'sd32768)
            return -16'sh8000;
        else
            return q[15:0];
    endfunction

    assign in_ready  = !busy_reg && !hold_valid_reg;
    assign cfg_ready = 1'b1;
    assign acc_in    = in_valid && in_ready;
    assign done      = chain[BANDS].valid;
    assign hold_move = hold_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        start_tok.valid = acc_in && (in_data.op == OP_FRAME) && enable_reg;
        start_tok.left  = 32'(in_data.left_in) <<< STATE_FRAC;
        start_tok.right = 32'(in_data.right_in) <<< STATE_FRAC;
        coef_wr.en      = acc_in && (in_data.op == OP_LOAD);
        coef_wr.band    = in_data.band_sel;
        coef_wr.slot    = in_data.coef_sel;
        coef_wr.value   = in_data.coef_value;
        clear           = acc_in && (in_data.op == OP_CLEAR);
        res_l           = to_sample(chain[BANDS].left);
        res_r           = to_sample(chain[BANDS].right);
    end

    assign chain[0] = start_tok;

    for (genvar b = 0; b < BANDS; b++)
    begin : g_band
        sfbeq_cell #(
            .IDX       (b),
            .COEF_FRAC (COEF_FRAC)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[b]),
            .coef_wr (coef_wr),
            .clear   (clear),
            .tok_out (chain[b+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                enable_reg <= cfg_data;
            if (start_tok.valid)
                busy_reg <= 1'b1;
            else if (done)
                busy_reg <= 1'b0;
            if (hold_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (done || (acc_in && (in_data.op == OP_FRAME) && !enable_reg))
                hold_valid_reg <= 1'b1;
            else if (hold_move)
                hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            hold_reg.left_out  <= res_l;
            hold_reg.right_out <= res_r;
        end
        else if (acc_in)
        begin
            hold_reg.left_out  <= in_data.left_in;
            hold_reg.right_out <= in_data.right_in;
        end
        if (hold_move)
            out_reg <= hold_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && hold_valid_reg))
        else $error("frame in flight while a word is held");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg)
        else $error("chain finished with no frame in flight");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_tok.valid |=> busy_reg && !hold_valid_reg)
        else $error("filtered frame not marked in flight");
`endif

endmodule
